// ===== src/siq_pkg.sv =====
// shared codes, field widths and controller/datapath interface types
package siq_pkg;

  localparam int REQ_W   = 2;
  localparam int PHASE_W = 2;
  localparam int CODE_W  = 3;
  localparam int COUNT_W = 4;

  localparam logic [REQ_W-1:0] REQ_STATUS   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REGISTER = 2'd1;
  localparam logic [REQ_W-1:0] REQ_POP      = 2'd2;

  localparam logic [PHASE_W-1:0] PHASE_OTHER        = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_ESTABLISHING = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_ACTIVE       = 2'd2;

  localparam logic [CODE_W-1:0] CODE_NONE      = 3'd0;
  localparam logic [CODE_W-1:0] CODE_SEARCHING = 3'd1;
  localparam logic [CODE_W-1:0] CODE_HOME      = 3'd2;
  localparam logic [CODE_W-1:0] CODE_DEREG     = 3'd3;
  localparam logic [CODE_W-1:0] CODE_ATTACHING = 3'd4;
  localparam logic [CODE_W-1:0] CODE_ATTACHED  = 3'd5;
  localparam logic [CODE_W-1:0] CODE_DETACHED  = 3'd6;

  // commands from controller to datapath
  typedef struct packed {
    logic              accept;       // latch the input beat
    logic              push_en;      // enqueue push_code unless full
    logic [CODE_W-1:0] push_code;
    logic              pos_load;     // scan pointer to head
    logic              pos_advance;
    logic              rd_pos;       // read slot at scan pointer
    logic              rd_next;      // read slot after scan pointer
    logic              rd_head;
    logic              head_adv;
    logic              wr_shift;     // slot at scan pointer takes read data
    logic              tail_dec;
    logic              pop_cap;
    logic              prev_update;
    logic              load_out;
  } siq_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             home_edge;
    logic             dereg_edge;
    logic             est_edge;
    logic             act_enter;
    logic             act_leave;
    logic             empty;
    logic             pos_at_tail;
    logic             next_at_tail;
    logic             rd_match;
    logic             out_free;
  } siq_stat_t;

endpackage

// ===== src/status_indication_queue_core.sv =====
// top level of the status indication queue
//
// Input channel (in_valid / in_stall) carries one request per beat: a status
// update (registration bit and session phase), a register request, or a pop.
// Output channel (out_valid / out_stall) returns exactly one beat per request:
// the popped code (none for non-pop requests or an empty ring) and the number
// of codes left queued. The ring holds RING_SLOTS-1 codes; extra codes are
// dropped.
// One request is in flight at a time; in_stall is high from the accepting edge
// until the result is loaded into the output register. A register request or
// an unused kind goes from dispatch straight to finish; a pop reads the head
// slot and captures it unless the ring is empty. An active-phase edge adds a
// scan of the single-port slot memory: a search from the head for the oldest
// attaching code, then a shift of the later slots toward the head. The next
// request can be taken in the cycle after the result loads.
// The output register lets the next request be accepted while a result waits;
// a stalled result holds, and the controller waits before loading another.
// Reset empties the ring and sets the previous status to not registered,
// other phase; slot contents are not cleared and need no clearing pass.
module status_indication_queue_core
  import siq_pkg::*;
#(
  parameter int RING_SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [REQ_W-1:0]   req_type,
  input  logic               is_home,
  input  logic [PHASE_W-1:0] sm_phase,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CODE_W-1:0]  popped_code,
  output logic [COUNT_W-1:0] queued_count
);

  siq_cmd_t  cmd;
  siq_stat_t stat;

  siq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  siq_dp #(
    .RING_SLOTS (RING_SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .req_type     (req_type),
    .is_home      (is_home),
    .sm_phase     (sm_phase),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .popped_code  (popped_code),
    .queued_count (queued_count)
  );

endmodule

// ===== src/siq_ctrl.sv =====
// sequencing state machine for requests, search, shift and pop
module siq_ctrl
  import siq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  siq_stat_t stat,
  output siq_cmd_t  cmd
);

  typedef enum logic [11:0] {
    S_IDLE      = 12'b0000_0000_0001,
    S_DISPATCH  = 12'b0000_0000_0010,
    S_PUSH_REG  = 12'b0000_0000_0100,
    S_PUSH_EST  = 12'b0000_0000_1000,
    S_SRCH      = 12'b0000_0001_0000,
    S_SRCH_CHK  = 12'b0000_0010_0000,
    S_SHIFT     = 12'b0000_0100_0000,
    S_SHIFT_WR  = 12'b0000_1000_0000,
    S_PUSH_PH   = 12'b0001_0000_0000,
    S_POP       = 12'b0010_0000_0000,
    S_POP_CAP   = 12'b0100_0000_0000,
    S_FINISH    = 12'b1000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.req)
          REQ_STATUS: state_next = S_PUSH_REG;
          REQ_REGISTER: begin
            cmd.push_en   = 1'b1;
            cmd.push_code = CODE_SEARCHING;
            state_next    = S_FINISH;
          end
          REQ_POP: state_next = S_POP;
          default: state_next = S_FINISH;
        endcase
      end
      S_PUSH_REG: begin
        cmd.push_en   = stat.home_edge | stat.dereg_edge;
        cmd.push_code = stat.home_edge ? CODE_HOME : CODE_DEREG;
        state_next    = S_PUSH_EST;
      end
      S_PUSH_EST: begin
        cmd.push_en   = stat.est_edge;
        cmd.push_code = CODE_ATTACHING;
        if (stat.act_enter || stat.act_leave) begin
          cmd.pos_load = 1'b1;
          state_next   = S_SRCH;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SRCH: begin
        if (stat.pos_at_tail) begin
          state_next = S_PUSH_PH;
        end else begin
          cmd.rd_pos = 1'b1;
          state_next = S_SRCH_CHK;
        end
      end
      S_SRCH_CHK: begin
        if (stat.rd_match) begin
          state_next = S_SHIFT;
        end else begin
          cmd.pos_advance = 1'b1;
          state_next      = S_SRCH;
        end
      end
      S_SHIFT: begin
        if (stat.next_at_tail) begin
          cmd.tail_dec = 1'b1;
          state_next   = S_PUSH_PH;
        end else begin
          cmd.rd_next = 1'b1;
          state_next  = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_shift    = 1'b1;
        cmd.pos_advance = 1'b1;
        state_next      = S_SHIFT;
      end
      S_PUSH_PH: begin
        cmd.push_en   = 1'b1;
        cmd.push_code = stat.act_enter ? CODE_ATTACHED : CODE_DETACHED;
        state_next    = S_FINISH;
      end
      S_POP: begin
        if (stat.empty) begin
          state_next = S_FINISH;
        end else begin
          cmd.rd_head  = 1'b1;
          cmd.head_adv = 1'b1;
          state_next   = S_POP_CAP;
        end
      end
      S_POP_CAP: begin
        cmd.pop_cap = 1'b1;
        state_next  = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.load_out    = 1'b1;
          cmd.prev_update = (stat.req == REQ_STATUS);
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== src/siq_dp.sv =====
// ring memory, pointers, edge detection and output register
module siq_dp
  import siq_pkg::*;
#(
  parameter int RING_SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [REQ_W-1:0]   req_type,
  input  logic               is_home,
  input  logic [PHASE_W-1:0] sm_phase,
  input  siq_cmd_t           cmd,
  output siq_stat_t          stat,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CODE_W-1:0]  popped_code,
  output logic [COUNT_W-1:0] queued_count
);

  localparam int PW = $clog2(RING_SLOTS);
  localparam logic [PW-1:0] LAST = PW'(RING_SLOTS - 1);

  logic [CODE_W-1:0]  mem [RING_SLOTS];
  logic [CODE_W-1:0]  rd_data;
  logic [PW-1:0]      head;
  logic [PW-1:0]      tail;
  logic [PW-1:0]      pos;
  logic               prev_reg;
  logic [PHASE_W-1:0] prev_phase;
  logic [REQ_W-1:0]   req_q;
  logic               reg_q;
  logic [PHASE_W-1:0] phase_q;
  logic [CODE_W-1:0]  popped;

  logic [PW-1:0]      head_next;
  logic [PW-1:0]      tail_next;
  logic [PW-1:0]      pos_next;
  logic [PW-1:0]      tail_prev;
  logic               full;
  logic               push_ok;
  logic               wr_en;
  logic [PW-1:0]      wr_addr;
  logic [CODE_W-1:0]  wr_data;
  logic               rd_en;
  logic [PW-1:0]      rd_addr;
  logic [PW:0]        count_wide;
  logic [PW-1:0]      count;
  logic [PW+COUNT_W:0] count_ext;

  assign head_next = (head == LAST) ? '0 : head + 1'b1;
  assign tail_next = (tail == LAST) ? '0 : tail + 1'b1;
  assign pos_next  = (pos == LAST) ? '0 : pos + 1'b1;
  assign tail_prev = (tail == '0) ? LAST : tail - 1'b1;

  assign full    = (tail_next == head);
  assign push_ok = cmd.push_en && !full;

  assign wr_en   = push_ok || cmd.wr_shift;
  assign wr_addr = cmd.wr_shift ? pos : tail;
  assign wr_data = cmd.wr_shift ? rd_data : cmd.push_code;

  assign rd_en = cmd.rd_pos || cmd.rd_next || cmd.rd_head;
  always_comb begin
    priority if (cmd.rd_head) begin
      rd_addr = head;
    end else if (cmd.rd_next) begin
      rd_addr = pos_next;
    end else begin
      rd_addr = pos;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // ring pointers and previous status
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      prev_reg   <= 1'b0;
      prev_phase <= PHASE_OTHER;
    end else begin
      if (cmd.head_adv) begin
        head <= head_next;
      end
      if (push_ok) begin
        tail <= tail_next;
      end else if (cmd.tail_dec) begin
        tail <= tail_prev;
      end
      if (cmd.prev_update) begin
        prev_reg   <= reg_q;
        prev_phase <= phase_q;
      end
    end
  end

  // latched request and scan pointer
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_q   <= req_type;
      reg_q   <= is_home;
      phase_q <= (sm_phase > PHASE_ACTIVE) ? PHASE_OTHER : sm_phase;
      popped  <= CODE_NONE;
    end else if (cmd.pop_cap) begin
      popped <= rd_data;
    end
    if (cmd.pos_load) begin
      pos <= head;
    end else if (cmd.pos_advance) begin
      pos <= pos_next;
    end
  end

  assign count_wide = (tail < head) ? ({1'b0, tail} + (PW+1)'(RING_SLOTS) - {1'b0, head})
                                    : ({1'b0, tail} - {1'b0, head});
  assign count     = count_wide[PW-1:0];
  assign count_ext = (PW+COUNT_W+1)'(count);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      popped_code  <= popped;
      queued_count <= count_ext[COUNT_W-1:0];
    end
  end

  always_comb begin
    stat              = '0;
    stat.req          = req_q;
    stat.home_edge    = !prev_reg && reg_q;
    stat.dereg_edge   = prev_reg && !reg_q;
    stat.est_edge     = (prev_phase != PHASE_ESTABLISHING) && (phase_q == PHASE_ESTABLISHING);
    stat.act_enter    = (prev_phase != PHASE_ACTIVE) && (phase_q == PHASE_ACTIVE);
    stat.act_leave    = (prev_phase == PHASE_ACTIVE) && (phase_q != PHASE_ACTIVE);
    stat.empty        = (head == tail);
    stat.pos_at_tail  = (pos == tail);
    stat.next_at_tail = (pos_next == tail);
    stat.rd_match     = (rd_data == CODE_ATTACHING);
    stat.out_free     = !out_valid || !out_stall;
  end

endmodule

// ===== src/siq_checker.sv =====
// port-level checks for the status indication queue, bound to the top level
module siq_checker
  import siq_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [CODE_W-1:0]  popped_code,
  input logic [COUNT_W-1:0] queued_count
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(popped_code) && $stable(queued_count))
    else $error("stalled result beat changed");

  // one request in flight: busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  // a new result only appears while a request is being worked on
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a request in flight");

  // only defined codes come out
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> popped_code <= CODE_DETACHED)
    else $error("undefined indication code");

endmodule

bind status_indication_queue_core siq_checker u_siq_checker (.*);

// ===== test/tb_top.sv =====
// testbench for status_indication_queue_core: directed table, then random traffic
module tb_top;
  import siq_pkg::*;

  localparam logic [REQ_W-1:0]   REQ_UNUSED   = 2'd3;
  localparam logic [PHASE_W-1:0] PHASE_UNUSED = 2'd3;
  localparam int RANDOM_BEATS = 1300;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int SETTLE_CYCLES = 48;
  localparam int HOLD_AT     = 950;
  localparam int HOLD_CYCLES = 250;

  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [COUNT_W-1:0] count;
  } indication_t;

  typedef struct packed {
    logic [REQ_W-1:0]   req;
    logic               reg_home;
    logic [PHASE_W-1:0] phase;
    logic [4:0]         reps;
    logic               typed;
    logic [CODE_W-1:0]  code;
    logic [COUNT_W-1:0] count;
  } plan_row_t;

  localparam int PLAN_ROWS = 22;
  localparam plan_row_t PLAN [0:PLAN_ROWS-1] = '{
    '{REQ_POP,      1'b0, PHASE_OTHER,        5'd1,  1'b1, CODE_NONE,      4'd0},
    '{REQ_UNUSED,   1'b1, PHASE_UNUSED,       5'd1,  1'b1, CODE_NONE,      4'd0},
    '{REQ_REGISTER, 1'b0, PHASE_OTHER,        5'd1,  1'b1, CODE_NONE,      4'd1},
    '{REQ_POP,      1'b1, PHASE_ACTIVE,       5'd1,  1'b1, CODE_SEARCHING, 4'd0},
    '{REQ_STATUS,   1'b1, PHASE_OTHER,        5'd1,  1'b1, CODE_NONE,      4'd1},
    '{REQ_STATUS,   1'b1, PHASE_ESTABLISHING, 5'd1,  1'b1, CODE_NONE,      4'd2},
    '{REQ_STATUS,   1'b1, PHASE_ACTIVE,       5'd1,  1'b1, CODE_NONE,      4'd2},
    '{REQ_STATUS,   1'b0, PHASE_UNUSED,       5'd1,  1'b1, CODE_NONE,      4'd4},
    '{REQ_POP,      1'b0, PHASE_OTHER,        5'd1,  1'b1, CODE_HOME,      4'd3},
    '{REQ_POP,      1'b0, PHASE_OTHER,        5'd1,  1'b1, CODE_ATTACHED,  4'd2},
    '{REQ_POP,      1'b0, PHASE_OTHER,        5'd1,  1'b1, CODE_DEREG,     4'd1},
    '{REQ_POP,      1'b0, PHASE_OTHER,        5'd1,  1'b1, CODE_DETACHED,  4'd0},
    '{REQ_POP,      1'b1, PHASE_UNUSED,       5'd1,  1'b1, CODE_NONE,      4'd0},
    '{REQ_REGISTER, 1'b1, PHASE_UNUSED,       5'd15, 1'b0, CODE_NONE,      4'd0},
    '{REQ_REGISTER, 1'b0, PHASE_OTHER,        5'd1,  1'b1, CODE_NONE,      4'd15},
    '{REQ_STATUS,   1'b0, PHASE_ESTABLISHING, 5'd1,  1'b1, CODE_NONE,      4'd15},
    '{REQ_POP,      1'b0, PHASE_OTHER,        5'd3,  1'b0, CODE_NONE,      4'd0},
    '{REQ_STATUS,   1'b0, PHASE_OTHER,        5'd1,  1'b1, CODE_NONE,      4'd12},
    '{REQ_STATUS,   1'b0, PHASE_ESTABLISHING, 5'd1,  1'b1, CODE_NONE,      4'd13},
    '{REQ_REGISTER, 1'b0, PHASE_OTHER,        5'd1,  1'b1, CODE_NONE,      4'd14},
    '{REQ_STATUS,   1'b0, PHASE_ACTIVE,       5'd1,  1'b1, CODE_NONE,      4'd14},
    '{REQ_STATUS,   1'b0, PHASE_ESTABLISHING, 5'd1,  1'b1, CODE_NONE,      4'd15}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [REQ_W-1:0]   req_type = REQ_STATUS;
  logic               is_home = 1'b0;
  logic [PHASE_W-1:0] sm_phase = PHASE_OTHER;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [CODE_W-1:0]  popped_code;
  logic [COUNT_W-1:0] queued_count;

  status_indication_queue_core uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .is_home(is_home),
    .sm_phase(sm_phase),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .popped_code(popped_code),
    .queued_count(queued_count)
  );

  // predictor state: 16-slot ring, 4-bit pointers wrap on their own
  logic [CODE_W-1:0]  ring_mem [16];
  logic [3:0]         ring_head = 4'd0;
  logic [3:0]         ring_tail = 4'd0;
  logic               last_reg = 1'b0;
  logic [PHASE_W-1:0] last_phase = PHASE_OTHER;

  indication_t pending_results [$];
  int  beats_in = 0;
  int  cycle_count = 0;
  int  fail_count = 0;
  bit  no_idle = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic void ring_push(logic [CODE_W-1:0] code);
    if (ring_tail + 4'd1 == ring_head) return;
    ring_mem[ring_tail] = code;
    ring_tail = ring_tail + 4'd1;
  endfunction

  function automatic logic [CODE_W-1:0] ring_pop();
    logic [CODE_W-1:0] code;
    if (ring_head == ring_tail) return CODE_NONE;
    code = ring_mem[ring_head];
    ring_head = ring_head + 4'd1;
    return code;
  endfunction

  // drop the oldest attaching code and close the gap toward the head
  function automatic void drop_oldest_attaching();
    logic [3:0] pos;
    pos = ring_head;
    while (pos != ring_tail && ring_mem[pos] != CODE_ATTACHING) pos = pos + 4'd1;
    if (pos == ring_tail) return;
    while (pos + 4'd1 != ring_tail) begin
      ring_mem[pos] = ring_mem[pos + 4'd1];
      pos = pos + 4'd1;
    end
    ring_tail = ring_tail - 4'd1;
  endfunction

  function automatic indication_t predict_indication(logic [REQ_W-1:0] rq, logic rg,
                                                     logic [PHASE_W-1:0] ph);
    indication_t res;
    logic [PHASE_W-1:0] phase;
    res.code = CODE_NONE;
    case (rq)
      REQ_STATUS: begin
        phase = (ph == PHASE_UNUSED) ? PHASE_OTHER : ph;
        if (!last_reg && rg) ring_push(CODE_HOME);
        if (last_reg && !rg) ring_push(CODE_DEREG);
        if (last_phase != PHASE_ESTABLISHING && phase == PHASE_ESTABLISHING)
          ring_push(CODE_ATTACHING);
        if (last_phase != PHASE_ACTIVE && phase == PHASE_ACTIVE) begin
          drop_oldest_attaching();
          ring_push(CODE_ATTACHED);
        end
        if (last_phase == PHASE_ACTIVE && phase != PHASE_ACTIVE) begin
          drop_oldest_attaching();
          ring_push(CODE_DETACHED);
        end
        last_reg = rg;
        last_phase = phase;
      end
      REQ_REGISTER: ring_push(CODE_SEARCHING);
      REQ_POP: res.code = ring_pop();
      default: ;
    endcase
    res.count = ring_tail - ring_head;
    return res;
  endfunction

  task automatic offer_beat(input logic [REQ_W-1:0] rq, input logic rg,
                            input logic [PHASE_W-1:0] ph, input logic typed,
                            input logic [CODE_W-1:0] tcode,
                            input logic [COUNT_W-1:0] tcount);
    indication_t res;
    while (!no_idle && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rq;
    is_home <= rg;
    sm_phase <= ph;
    do @(posedge clk); while (in_stall);
    beats_in++;
    res = predict_indication(rq, rg, ph);
    if (typed) begin
      res.code = tcode;
      res.count = tcount;
    end
    pending_results.push_back(res);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // receiver pacing, with one long hold-off so the block backs up
  initial begin : rx_pacing
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && beats_in >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (no_idle) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 37);
      end
    end
  end

  always @(posedge clk) begin
    indication_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: code %0d count %0d", popped_code, queued_count);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (popped_code !== want.code) begin
          $error("popped_code mismatch: expected %0d, got %0d", want.code, popped_code);
          fail_count++;
        end
        if (queued_count !== want.count) begin
          $error("queued_count mismatch: expected %0d, got %0d", want.count, queued_count);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    int i;
    int r;
    int pop_bias;
    logic [REQ_W-1:0]   rq;
    logic               rg;
    logic [PHASE_W-1:0] ph;
    logic [PHASE_W-1:0] walk_phase;
    logic               walk_reg;
    pop_bias = 30;
    walk_phase = PHASE_OTHER;
    walk_reg = 1'b0;
    do @(posedge clk); while (rst);

    for (int k = 0; k < PLAN_ROWS; k++)
      repeat (PLAN[k].reps)
        offer_beat(PLAN[k].req, PLAN[k].reg_home, PLAN[k].phase, PLAN[k].typed,
                   PLAN[k].code, PLAN[k].count);

    for (i = 0; i < RANDOM_BEATS; i++) begin
      // shift between filling and draining phases
      if (i % 60 == 0) begin
        case ($urandom_range(3))
          0: pop_bias = 8;
          1: pop_bias = 30;
          2: pop_bias = 45;
          default: pop_bias = 70;
        endcase
      end
      no_idle = (i >= 400 && i < 600);
      if (i == 750) wait_for_drain();

      r = $urandom_range(99);
      rg = 1'($urandom_range(1));
      ph = PHASE_W'($urandom_range(3));
      if (r < pop_bias) begin
        rq = REQ_POP;
      end else if (r < pop_bias + 4) begin
        rq = REQ_UNUSED;
      end else if (r < pop_bias + 16) begin
        rq = REQ_REGISTER;
      end else begin
        rq = REQ_STATUS;
        if ($urandom_range(3) == 0) walk_reg = ~walk_reg;
        rg = walk_reg;
        // mostly a plausible session walk, sometimes any phase
        if ($urandom_range(9) < 7) begin
          case (walk_phase)
            PHASE_OTHER: walk_phase = PHASE_ESTABLISHING;
            PHASE_ESTABLISHING:
              walk_phase = ($urandom_range(4) == 0) ? PHASE_OTHER : PHASE_ACTIVE;
            default: walk_phase = $urandom_range(1) ? PHASE_OTHER : PHASE_ESTABLISHING;
          endcase
          ph = walk_phase;
        end else begin
          walk_phase = (ph == PHASE_UNUSED) ? PHASE_OTHER : ph;
        end
      end
      offer_beat(rq, rg, ph, 1'b0, CODE_NONE, 4'd0);
    end
    no_idle = 1'b0;

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
